@@ rtl/decimal_entry_seven_segment_scanner_top_defines.svh @@
// Assertion helpers used by dess_core; empty in synthesis.
`ifndef DECIMAL_ENTRY_SEVEN_SEGMENT_SCANNER_TOP_DEFINES_SVH
`define DECIMAL_ENTRY_SEVEN_SEGMENT_SCANNER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DESS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DESS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DESS_ASSERT(lbl, prop, msg)
`define DESS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/dess_pkg.sv @@
package dess_pkg;

    typedef enum logic
    {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        PROMPT_NONE   = 2'd0,
        PROMPT_SECOND = 2'd1,
        PROMPT_DONE   = 2'd2
    } prompt_t;

    localparam logic [7:0]  CHAR_ZERO         = 8'h30;
    localparam logic [7:0]  CHAR_NINE         = 8'h39;
    localparam logic [3:0]  ENTRY_HALF        = 4'd4;
    localparam logic [3:0]  ENTRY_FULL        = 4'd8;
    localparam logic [15:0] FIRST_TICKS_RESET = 16'd3000;

    typedef struct packed
    {
        opcode_t    opcode;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed
    {
        logic       display_update;
        logic [3:0] digit_enable;
        logic [6:0] segments;
        prompt_t    prompt;
        logic       byte_rejected;
        logic       entry_done;
    } result_t;

    // bit0 = segment a .. bit6 = segment g; codes above nine are blank
    function automatic logic [6:0] seg_lut(input logic [3:0] digit);
        logic [6:0] pattern;
        unique case (digit)
            4'd0:    pattern = 7'h3f;
            4'd1:    pattern = 7'h06;
            4'd2:    pattern = 7'h5b;
            4'd3:    pattern = 7'h4f;
            4'd4:    pattern = 7'h66;
            4'd5:    pattern = 7'h6d;
            4'd6:    pattern = 7'h7d;
            4'd7:    pattern = 7'h07;
            4'd8:    pattern = 7'h7f;
            4'd9:    pattern = 7'h6f;
            default: pattern = 7'h00;
        endcase
        return pattern;
    endfunction

endpackage

@@ rtl/dess_core.sv @@
`include "decimal_entry_seven_segment_scanner_top_defines.svh"

module dess_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  dess_pkg::item_t  item,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_data,
    output dess_pkg::result_t res
);
    import dess_pkg::*;

    logic [3:0]  digit_store_reg [8];
    logic [3:0]  entry_count_reg;
    logic [3:0]  entry_count_next;
    logic [1:0]  scan_pos_reg;
    logic [1:0]  scan_pos_next;
    logic [15:0] phase_count_reg;
    logic [15:0] phase_count_next;
    logic [15:0] first_ticks_reg;

    logic        is_tick;
    logic        is_digit;
    logic [7:0]  char_offset;
    logic        store_en;
    logic        show_first;
    logic        number_ready;
    logic [2:0]  rd_idx;
    logic [3:0]  shown_digit;
    prompt_t     prompt_val;

    assign is_tick     = (item.opcode == OP_TICK);
    assign is_digit    = (item.rx_byte >= CHAR_ZERO) && (item.rx_byte <= CHAR_NINE);
    assign char_offset = item.rx_byte - CHAR_ZERO;
    assign store_en    = fire && !is_tick && is_digit && (entry_count_reg < ENTRY_FULL);

    assign show_first   = (phase_count_reg < first_ticks_reg);
    assign number_ready = show_first ? (entry_count_reg >= ENTRY_HALF)
                                     : (entry_count_reg >= ENTRY_FULL);
    // first number in entries 0..3, second in 4..7, most significant first
    assign rd_idx       = {!show_first, ~scan_pos_reg};
    assign shown_digit  = number_ready ? digit_store_reg[rd_idx] : 4'd0;

    always_comb
    begin
        entry_count_next = entry_count_reg;
        scan_pos_next    = scan_pos_reg;
        phase_count_next = phase_count_reg;
        prompt_val       = PROMPT_NONE;
        if (store_en)
        begin
            entry_count_next = entry_count_reg + 4'd1;
            if (entry_count_next == ENTRY_HALF)
            begin
                prompt_val = PROMPT_SECOND;
            end
            else if (entry_count_next == ENTRY_FULL)
            begin
                prompt_val = PROMPT_DONE;
            end
        end
        if (fire && is_tick)
        begin
            scan_pos_next = scan_pos_reg + 2'd1;
            if (show_first)
            begin
                phase_count_next = phase_count_reg + 16'd1;
            end
        end
    end

    always_comb
    begin
        res.display_update = is_tick;
        res.digit_enable   = is_tick ? (4'b1000 >> scan_pos_reg) : 4'd0;
        res.segments       = is_tick ? seg_lut(shown_digit) : 7'd0;
        res.prompt         = prompt_val;
        res.byte_rejected  = !is_tick && !is_digit;
        res.entry_done     = (entry_count_next >= ENTRY_FULL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= 4'd0;
            scan_pos_reg    <= 2'd0;
            phase_count_reg <= 16'd0;
            first_ticks_reg <= FIRST_TICKS_RESET;
            for (int i = 0; i < 8; i++)
            begin
                digit_store_reg[i] <= 4'd0;
            end
        end
        else
        begin
            entry_count_reg <= entry_count_next;
            scan_pos_reg    <= scan_pos_next;
            phase_count_reg <= phase_count_next;
            if (cfg_we)
            begin
                first_ticks_reg <= cfg_data;
            end
            if (store_en)
            begin
                digit_store_reg[entry_count_reg[2:0]] <= char_offset[3:0];
            end
        end
    end

    `DESS_ASSERT(a_count_range, entry_count_reg <= ENTRY_FULL, "entry count past eight")
    `DESS_ASSERT(a_tick_onehot, !(fire && is_tick) || $onehot(res.digit_enable), "enable not one-hot")
    `DESS_ASSERT_NEXT(a_full_holds, entry_count_reg == ENTRY_FULL, entry_count_reg == ENTRY_FULL, "entry count left full")
    `DESS_ASSERT_NEXT(a_scan_step, fire && is_tick, scan_pos_reg == 2'($past(scan_pos_reg) + 2'd1), "scan position did not step")
    `DESS_ASSERT_NEXT(a_byte_no_scan, fire && !is_tick, $stable(scan_pos_reg) && $stable(phase_count_reg), "byte moved the scan")

endmodule

@@ rtl/dess_out_reg.sv @@
module dess_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  dess_pkg::result_t res,
    input  logic              m_axis_tready,
    output logic              m_axis_tvalid,
    output logic [15:0]       m_axis_tdata,   // digit_enable, segments, prompt, byte_rejected, entry_done
    output logic              m_axis_tuser    // display_update
);
    import dess_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign valid_next = load ? 1'b1 : (valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = res_reg.display_update;
    assign m_axis_tdata  = {1'b0, res_reg.entry_done, res_reg.byte_rejected, res_reg.prompt,
                            res_reg.segments, res_reg.digit_enable};

endmodule

@@ rtl/decimal_entry_seven_segment_scanner_top.sv @@
// A result beat passes the input register, then the result register; it waits
// in the input register while the result register holds an untaken beat.
// Throughput: one beat per cycle while m_axis_tready stays high.
// Reset (rst_n low, asynchronous): digits and counters clear, display shows
// 0000, first_ticks returns to 3000, both stages empty.
module decimal_entry_seven_segment_scanner_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // digit_enable, segments, prompt, byte_rejected, entry_done
    output logic        m_axis_tuser,   // display_update
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import dess_pkg::*;

    logic  in_valid_reg;
    logic  in_valid_next;
    item_t in_item_reg;
    logic  advance;
    logic  s_fire;
    result_t res;

    assign advance       = in_valid_reg && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign in_valid_next = s_fire || (in_valid_reg && !advance);
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg <= '{opcode: opcode_t'(s_axis_tuser), rx_byte: s_axis_tdata};
        end
    end

    dess_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .item     (in_item_reg),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .res      (res)
    );

    dess_out_reg u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .res           (res),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
